[rtl/sv39ptw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptw_pkg
// Shared types and constants for the Sv39 page table map and walk block.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

    localparam int TABLE_PAGES = 128;
    localparam int ENTRIES     = 512;
    localparam int VPN_W       = 9;
    localparam int PAGE_W      = $clog2(TABLE_PAGES);
    localparam int ADDR_W      = PAGE_W + VPN_W;
    localparam int NFREE_W     = $clog2(TABLE_PAGES + 1);
    localparam int PPN_W       = 44;
    localparam int ENTRY_W     = 54;
    localparam int VA_W        = 39;
    localparam int CVA_W       = 40;
    localparam int OFF_W       = 12;
    localparam int CNT_W       = 16;
    localparam int PERM_W      = 4;
    localparam int FLAG_W      = 5;
    localparam int PA_W        = 56;
    localparam int ST_W        = 3;

    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_UNMAPPED   = 3'd1;
    localparam logic [ST_W-1:0] ST_RANGE      = 3'd2;
    localparam logic [ST_W-1:0] ST_MISALIGNED = 3'd3;
    localparam logic [ST_W-1:0] ST_ZERO       = 3'd4;
    localparam logic [ST_W-1:0] ST_REMAP      = 3'd5;
    localparam logic [ST_W-1:0] ST_NOSPACE    = 3'd6;

    localparam logic FUNC_XLATE = 1'b0;
    localparam logic FUNC_MAP   = 1'b1;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [ENTRY_W-1:0] wdata;
        logic [ADDR_W-1:0]  raddr;
    } mem_req_t;

endpackage
`default_nettype wire

[rtl/sv39ptw_mem.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptw_mem
// Table page store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sv39ptw_mem
(
    input  wire logic                               clk,
    input  wire sv39ptw_pkg::mem_req_t              req,
    output logic [sv39ptw_pkg::ENTRY_W-1:0]         rdata
);

    logic [sv39ptw_pkg::ENTRY_W-1:0] mem [sv39ptw_pkg::TABLE_PAGES*sv39ptw_pkg::ENTRIES];

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        rdata <= mem[req.raddr];
    end

endmodule
`default_nettype wire

[rtl/sv39ptw_walk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sv39ptw_walk
// Sequencer: store clearing, table walk, table page allocation, leaf writes.
// ----------------------------------------------------------------------------
module sv39ptw_walk
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [sv39ptw_pkg::PPN_W-1:0]      cfg_wdata,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic                               in_func,
    input  wire logic [sv39ptw_pkg::VA_W-1:0]       in_va,
    input  wire logic [sv39ptw_pkg::PPN_W-1:0]      in_pp,
    input  wire logic [sv39ptw_pkg::CNT_W-1:0]      in_count,
    input  wire logic [sv39ptw_pkg::PERM_W-1:0]     in_perm,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [sv39ptw_pkg::ST_W-1:0]            out_status,
    output logic [sv39ptw_pkg::PA_W-1:0]            out_pa,
    output logic [sv39ptw_pkg::FLAG_W-1:0]          out_flags,
    output logic [sv39ptw_pkg::CNT_W-1:0]           out_pages,
    output sv39ptw_pkg::mem_req_t                   mem_req,
    input  wire logic [sv39ptw_pkg::ENTRY_W-1:0]    mem_rdata
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_CHK   = 6'b000100,
        S_RD    = 6'b001000,
        S_EVAL  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t                              state_reg, state_next;
    logic [sv39ptw_pkg::ADDR_W-1:0]      clr_reg, clr_next;
    logic [sv39ptw_pkg::PPN_W-1:0]       base_reg;
    logic [sv39ptw_pkg::NFREE_W-1:0]     nfree_reg, nfree_next;
    logic                                func_reg, func_next;
    logic [sv39ptw_pkg::CVA_W-1:0]       va_reg, va_next;
    logic [sv39ptw_pkg::PPN_W-1:0]       pp_reg, pp_next;
    logic [sv39ptw_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [sv39ptw_pkg::PERM_W-1:0]      perm_reg, perm_next;
    logic [sv39ptw_pkg::CNT_W-1:0]       done_reg, done_next;
    logic [1:0]                          level_reg, level_next;
    logic [sv39ptw_pkg::PAGE_W-1:0]      page_reg, page_next;
    logic [sv39ptw_pkg::ST_W-1:0]        st_reg, st_next;
    logic [sv39ptw_pkg::PA_W-1:0]        pa_reg, pa_next;
    logic [sv39ptw_pkg::FLAG_W-1:0]      flags_reg, flags_next;
    logic                                ov_reg, ov_next;
    logic [sv39ptw_pkg::VPN_W-1:0]       vpn;
    logic [sv39ptw_pkg::ADDR_W-1:0]      slot;
    logic [sv39ptw_pkg::PPN_W-1:0]       idx;
    logic [sv39ptw_pkg::PPN_W-1:0]       new_ptr;

    always_comb
    begin
        case (level_reg)
            2'd2:    vpn = va_reg[38:30];
            2'd1:    vpn = va_reg[29:21];
            default: vpn = va_reg[20:12];
        endcase
    end

    assign slot    = {page_reg, vpn};
    // shared subtract: pointer ppn back to pool page
    assign idx     = mem_rdata[53:10] - base_reg;
    assign new_ptr = base_reg + sv39ptw_pkg::PPN_W'(nfree_reg);

    // result registers are reused, so a new item waits for the pending transfer
    assign in_ready   = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid  = ov_reg;
    assign out_status = st_reg;
    assign out_pa     = pa_reg;
    assign out_flags  = flags_reg;
    assign out_pages  = done_reg;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        nfree_next = nfree_reg;
        func_next  = func_reg;
        va_next    = va_reg;
        pp_next    = pp_reg;
        count_next = count_reg;
        perm_next  = perm_reg;
        done_next  = done_reg;
        level_next = level_reg;
        page_next  = page_reg;
        st_next    = st_reg;
        pa_next    = pa_reg;
        flags_next = flags_reg;
        ov_next    = ov_reg && !out_ready;
        mem_req.we    = 1'b0;
        mem_req.waddr = slot;
        mem_req.wdata = '0;
        mem_req.raddr = slot;

        case (state_reg)
            S_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_reg;
                clr_next      = clr_reg + 1'b1;
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    func_next  = in_func;
                    va_next    = {1'b0, in_va};
                    pp_next    = in_pp;
                    count_next = in_count;
                    perm_next  = in_perm;
                    done_next  = '0;
                    pa_next    = '0;
                    flags_next = '0;
                    level_next = 2'd2;
                    page_next  = '0;
                    st_next    = sv39ptw_pkg::ST_OK;
                    if (in_func == sv39ptw_pkg::FUNC_XLATE)
                    begin
                        if (in_va[38])
                        begin
                            st_next    = sv39ptw_pkg::ST_RANGE;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    else if (in_va[sv39ptw_pkg::OFF_W-1:0] != '0)
                    begin
                        st_next    = sv39ptw_pkg::ST_MISALIGNED;
                        state_next = S_DONE;
                    end
                    else if (in_count == '0)
                    begin
                        st_next    = sv39ptw_pkg::ST_ZERO;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CHK;
                    end
                end
            end
            S_CHK:
            begin
                level_next = 2'd2;
                page_next  = '0;
                if (va_reg[39:38] != 2'b00)
                begin
                    st_next    = sv39ptw_pkg::ST_RANGE;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (level_reg != 2'd0)
                begin
                    if (mem_rdata[0])
                    begin
                        if (idx >= sv39ptw_pkg::PPN_W'(nfree_reg))
                        begin
                            st_next    = (func_reg == sv39ptw_pkg::FUNC_MAP)
                                         ? sv39ptw_pkg::ST_NOSPACE
                                         : sv39ptw_pkg::ST_UNMAPPED;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            page_next  = idx[sv39ptw_pkg::PAGE_W-1:0];
                            level_next = level_reg - 1'b1;
                            state_next = S_RD;
                        end
                    end
                    else if (func_reg == sv39ptw_pkg::FUNC_XLATE)
                    begin
                        st_next    = sv39ptw_pkg::ST_UNMAPPED;
                        state_next = S_DONE;
                    end
                    else if (nfree_reg >= sv39ptw_pkg::NFREE_W'(sv39ptw_pkg::TABLE_PAGES))
                    begin
                        st_next    = sv39ptw_pkg::ST_NOSPACE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // take a fresh table page and link it in
                        mem_req.we    = 1'b1;
                        mem_req.wdata = {new_ptr, 10'd0};
                        mem_req.wdata[0] = 1'b1;
                        page_next  = nfree_reg[sv39ptw_pkg::PAGE_W-1:0];
                        nfree_next = nfree_reg + 1'b1;
                        level_next = level_reg - 1'b1;
                        state_next = S_RD;
                    end
                end
                else if (func_reg == sv39ptw_pkg::FUNC_XLATE)
                begin
                    if (mem_rdata[0])
                    begin
                        pa_next    = {mem_rdata[53:10], va_reg[sv39ptw_pkg::OFF_W-1:0]};
                        flags_next = mem_rdata[4:0];
                    end
                    else
                    begin
                        st_next = sv39ptw_pkg::ST_UNMAPPED;
                    end
                    state_next = S_DONE;
                end
                else if (mem_rdata[0])
                begin
                    st_next    = sv39ptw_pkg::ST_REMAP;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_req.we    = 1'b1;
                    mem_req.wdata = {pp_reg, 5'd0, perm_reg, 1'b1};
                    done_next     = done_reg + 1'b1;
                    pp_next       = pp_reg + 1'b1;
                    va_next       = va_reg + (sv39ptw_pkg::CVA_W'(1) << sv39ptw_pkg::OFF_W);
                    state_next    = (done_next == count_reg) ? S_DONE : S_CHK;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            nfree_reg <= sv39ptw_pkg::NFREE_W'(1);
            base_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            nfree_reg <= nfree_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg  <= func_next;
        va_reg    <= va_next;
        pp_reg    <= pp_next;
        count_reg <= count_next;
        perm_reg  <= perm_next;
        done_reg  <= done_next;
        level_reg <= level_next;
        page_reg  <= page_next;
        st_reg    <= st_next;
        pa_reg    <= pa_next;
        flags_reg <= flags_next;
    end

endmodule
`default_nettype wire

[rtl/sv39_page_table_map_and_walk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sv39_page_table_map_and_walk
// Three-level Sv39 page table kept in an internal table page store.
// ----------------------------------------------------------------------------
// After reset the store is cleared one entry per cycle; s_tready stays low
// until then, configuration writes are taken meanwhile. One item is processed
// at a time; each table access is a read step (S_RD) followed by a check step
// (S_EVAL) on the store. A translate walks the table levels towards the leaf,
// and a map item writes a leaf per page and links in fresh table pages.
// The result stays in the output registers until its transfer; the next item
// is taken no earlier than the cycle of that transfer, so result stalls add
// directly to the item time.
// ----------------------------------------------------------------------------
module sv39_page_table_map_and_walk
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic [43:0]   cfg_wdata,     // table_base_ppn
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [103:0]  s_tdata,       // virtual_addr, phys_page, page_count, perm
    input  wire logic          s_tuser,       // func
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [79:0]        m_tdata,       // phys_addr, flags, pages_mapped
    output logic [2:0]         m_tuser        // status
);

    sv39ptw_pkg::mem_req_t              mem_req;
    logic [sv39ptw_pkg::ENTRY_W-1:0]    mem_rdata;
    logic [sv39ptw_pkg::PA_W-1:0]       pa;
    logic [sv39ptw_pkg::FLAG_W-1:0]     flags;
    logic [sv39ptw_pkg::CNT_W-1:0]      pages;

    sv39ptw_mem u_mem
    (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    sv39ptw_walk u_walk
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_func    (s_tuser),
        .in_va      (s_tdata[38:0]),
        .in_pp      (s_tdata[82:39]),
        .in_count   (s_tdata[98:83]),
        .in_perm    (s_tdata[102:99]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_pa     (pa),
        .out_flags  (flags),
        .out_pages  (pages),
        .mem_req    (mem_req),
        .mem_rdata  (mem_rdata)
    );

    assign m_tdata = {3'd0, pages, flags, pa};

endmodule
`default_nettype wire
